>>> src/pem_armor_base64_decoder_defines.svh
// Assertion macros for the PEM armor base64 decoder.
// Self-contained; included by the files that carry assertions.
`ifndef PEM_ARMOR_BASE64_DECODER_DEFINES_SVH
`define PEM_ARMOR_BASE64_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define PAB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pab assertion failed");
`define PAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pab assertion failed");
`else
`define PAB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PAB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/pab_pkg.sv
// Types, character codes and the base64 alphabet lookup for the PEM decoder.
// No dependencies.
`default_nettype none

package pab_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [2:0] RUN_LEN  = 3'd5;

    typedef enum logic [4:0] {
        PH_SEEK  = 5'b00001,
        PH_OPEN  = 5'b00010,
        PH_BODY  = 5'b00100,
        PH_CLOSE = 5'b01000,
        PH_HALT  = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // Results of one input transaction: up to three, delivered in order.
    typedef struct packed {
        t_kind      kind;
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_bundle;

    // Bit 6 set: not in the alphabet.
    function automatic logic [6:0] f_sextet(input logic [7:0] c);
        logic [6:0] v;
        v = 7'd64;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            v = 7'd62;
        end else if (c == 8'h2F) begin
            v = 7'd63;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> src/pab_in_if.sv
// Input channel of the PEM decoder: text byte and end-of-file flag.
// No dependencies.
`default_nettype none

interface pab_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       file_end;

    modport source (output valid, output in_byte, output file_end, input ready);
    modport sink   (input valid, input in_byte, input file_end, output ready);
endinterface

`default_nettype wire

>>> src/pab_out_if.sv
// Output channel of the PEM decoder: result kind, decoded byte, last flag.
// No dependencies.
`default_nettype none

interface pab_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output kind, output data_byte, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input last, output ready);
endinterface

`default_nettype wire

>>> src/pem_armor_base64_decoder.sv
// A transaction's results are written into the result queue when the transaction is accepted.
// Throughput: one input byte per cycle; results leave one per cycle while the output is ready, from a
// two-entry queue of per-transaction result groups, input stalls while it is full.
// Reset: synchronous, active low; clears parse state and the result queue.
// Depends on pab_pkg, pab_in_if, pab_out_if and the defines header.
`default_nettype none
`include "pem_armor_base64_decoder_defines.svh"

module pem_armor_base64_decoder (
    input  wire    i_clk,
    input  wire    i_rst_n,
    pab_in_if.sink     i_in,
    pab_out_if.source  o_out
);
    import pab_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_run, n_run;
    logic [1:0]  r_fill, n_fill;
    logic [17:0] r_bits, n_bits;
    logic [1:0]  r_pad, n_pad;
    logic        r_bad, n_bad;

    t_bundle     r_q0, r_q1, n_q0, n_q1;
    logic [1:0]  r_cnt, n_cnt;
    logic [1:0]  r_idx, n_idx;

    t_bundle     w_new;
    logic        w_gen;
    logic        w_acc;
    logic        w_pop_res;
    logic        w_pop_b;
    logic        w_push;
    logic        w_wpos;
    logic [7:0]  w_c;
    logic [6:0]  w_v;
    logic        w_ok;
    logic [23:0] w_word;

    assign w_acc = i_in.valid && i_in.ready;
    assign w_c   = i_in.in_byte;

    // Parse step
    always_comb begin
        n_phase = r_phase;
        n_run   = r_run;
        n_fill  = r_fill;
        n_bits  = r_bits;
        n_pad   = r_pad;
        n_bad   = r_bad;
        w_gen   = 1'b0;
        w_ok    = 1'b0;
        w_v     = f_sextet(w_c);
        w_word  = {r_bits, w_v[5:0]};
        w_new   = '{kind: KIND_DATA, cnt: 2'd1, b0: 8'd0, b1: 8'd0, b2: 8'd0};
        if (r_phase != PH_HALT) begin
            if (w_c == CH_NUL) begin
                n_phase = PH_HALT;
            end else if (w_c == CH_DASH) begin
                n_run = r_run + 3'd1;
                if (n_run >= RUN_LEN) begin
                    n_run = 3'd0;
                    case (r_phase)
                        PH_SEEK: begin
                            n_phase = PH_OPEN;
                        end
                        PH_OPEN: begin
                            n_fill  = 2'd0;
                            n_bits  = 18'd0;
                            n_pad   = 2'd0;
                            n_bad   = 1'b0;
                            n_phase = PH_BODY;
                        end
                        PH_BODY: begin
                            if (r_fill != 2'd0) begin
                                n_bad = 1'b1;
                            end
                            n_phase = PH_CLOSE;
                        end
                        PH_CLOSE: begin
                            w_gen    = 1'b1;
                            w_new.kind = r_bad ? KIND_ERR : KIND_END;
                            n_phase  = r_bad ? PH_HALT : PH_SEEK;
                            n_fill   = 2'd0;
                            n_bits   = 18'd0;
                            n_pad    = 2'd0;
                            n_bad    = 1'b0;
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end else begin
                if (r_phase == PH_BODY) begin
                    n_bad = r_bad || (r_run != 3'd0);
                    if (w_c != CH_CR && w_c != CH_LF && w_c != CH_TAB && w_c != CH_SPACE
                        && !n_bad) begin
                        if (w_c == CH_PAD) begin
                            if (r_fill < 2'd2) begin
                                n_bad = 1'b1;
                            end else begin
                                n_pad  = r_pad + 2'd1;
                                w_word = {r_bits, 6'd0};
                                w_ok   = 1'b1;
                            end
                        end else if (w_v[6] || r_pad != 2'd0) begin
                            n_bad = 1'b1;
                        end else begin
                            w_ok = 1'b1;
                        end
                        if (w_ok) begin
                            if (r_fill < 2'd3) begin
                                n_bits = w_word[17:0];
                                n_fill = r_fill + 2'd1;
                            end else begin
                                w_gen     = 1'b1;
                                w_new.b0  = w_word[23:16];
                                w_new.b1  = w_word[15:8];
                                w_new.b2  = w_word[7:0];
                                w_new.cnt = (n_pad == 2'd0) ? 2'd3 :
                                            (n_pad == 2'd1) ? 2'd2 : 2'd1;
                                n_fill    = 2'd0;
                                n_bits    = 18'd0;
                            end
                        end
                    end
                end
                n_run = 3'd0;
            end
        end
        if (i_in.file_end) begin
            n_phase = PH_SEEK;
            n_run   = 3'd0;
            n_fill  = 2'd0;
            n_bits  = 18'd0;
            n_pad   = 2'd0;
            n_bad   = 1'b0;
        end
    end

    // Result queue
    assign i_in.ready = (r_cnt != 2'd2);
    assign w_pop_res  = o_out.valid && o_out.ready;
    assign w_pop_b    = w_pop_res && (r_idx == r_q0.cnt - 2'd1);
    assign w_push     = w_acc && w_gen;
    assign w_wpos     = (r_cnt - {1'b0, w_pop_b}) != 2'd0;

    always_comb begin
        n_q0 = r_q0;
        n_q1 = r_q1;
        if (w_pop_b) begin
            n_q0 = r_q1;
        end
        if (w_push && !w_wpos) begin
            n_q0 = w_new;
        end
        if (w_push && w_wpos) begin
            n_q1 = w_new;
        end
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop_b};
        n_idx = w_pop_b ? 2'd0 : (w_pop_res ? r_idx + 2'd1 : r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_run   <= 3'd0;
            r_fill  <= 2'd0;
            r_bits  <= 18'd0;
            r_pad   <= 2'd0;
            r_bad   <= 1'b0;
            r_cnt   <= 2'd0;
            r_idx   <= 2'd0;
        end else begin
            if (w_acc) begin
                r_phase <= n_phase;
                r_run   <= n_run;
                r_fill  <= n_fill;
                r_bits  <= n_bits;
                r_pad   <= n_pad;
                r_bad   <= n_bad;
            end
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_out.valid = (r_cnt != 2'd0);
    assign o_out.kind  = r_q0.kind;
    assign o_out.last  = (r_idx == r_q0.cnt - 2'd1);

    always_comb begin
        case (r_idx)
            2'd0:    o_out.data_byte = r_q0.b0;
            2'd1:    o_out.data_byte = r_q0.b1;
            2'd2:    o_out.data_byte = r_q0.b2;
            default: o_out.data_byte = 8'd0;
        endcase
    end

    `PAB_ASSERT_SAME(a_idx_in_group, i_clk, i_rst_n, o_out.valid, r_idx < r_q0.cnt)
    `PAB_ASSERT_SAME(a_marker_no_data, i_clk, i_rst_n,
        o_out.valid && o_out.kind != KIND_DATA, o_out.data_byte == 8'd0 && o_out.last)
    `PAB_ASSERT_NEXT(a_drain_empty, i_clk, i_rst_n,
        w_pop_b && r_cnt == 2'd1 && !w_push, !o_out.valid)
    `PAB_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n,
        r_phase == PH_HALT && !(w_acc && i_in.file_end), r_phase == PH_HALT)

endmodule

`default_nettype wire

>>> tb/pem_armor_base64_decoder_test.sv
`timescale 1ns / 1ps
// Self-checking bench for pem_armor_base64_decoder: random PEM-like text in,
// decoded bytes and end/error markers checked against an in-bench decoder.
// Depends on pab_pkg, pab_in_if, pab_out_if and the decoder RTL.

module pem_armor_base64_decoder_test;
    import pab_pkg::*;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam int TEXT_ITEMS = 370;

    typedef enum int {
        FLT_NONE,
        FLT_BADCHAR,
        FLT_STRAY_DASH,
        FLT_PARTIAL,
        FLT_PAD_EARLY,
        FLT_AFTER_PAD,
        FLT_ZERO,
        FLT_TRUNCATE
    } t_fault;

    typedef struct packed {
        logic [7:0] ch;
        logic       fe;
    } t_text_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic       last;
    } t_decoded;

    logic i_clk;
    logic i_rst_n;

    pab_in_if  text_if();
    pab_out_if dec_if();

    pem_armor_base64_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_if),
        .o_out   (dec_if)
    );

    t_text_item text_q[$];
    t_decoded   decoded_q[$];
    logic [7:0] cert_body[$];
    int         noise_items;
    int         fail_count;

    t_text_item sent_item;
    int         send_gap;
    bit         send_burst;
    int         recv_stall;
    bit         recv_burst;
    t_decoded   want;

    // decoder state mirror
    t_phase      dec_phase;
    logic [2:0]  dash_cnt;
    logic [1:0]  grp_fill;
    logic [17:0] grp_bits;
    logic [1:0]  pad_cnt;
    logic        body_bad;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        fail_count++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    function automatic logic [6:0] b64_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
        if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 26)};
        if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 52)};
        if (c == CH_PLUS) return 7'd62;
        if (c == CH_SLASH) return 7'd63;
        return 7'h40;
    endfunction

    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        if (v == 62) return CH_PLUS;
        return CH_SLASH;
    endfunction

    function automatic void clear_group_state();
        grp_fill = '0;
        grp_bits = '0;
        pad_cnt  = '0;
        body_bad = 1'b0;
    endfunction

    function automatic void reset_model();
        dec_phase = PH_SEEK;
        dash_cnt  = '0;
        clear_group_state();
    endfunction

    // Predicts the results of one accepted text byte and queues them.
    function automatic void decode_step(input logic [7:0] c, input logic fe);
        t_decoded    step_out[$];
        logic [6:0]  sv;
        logic [5:0]  v;
        logic [23:0] word;
        bit          take;
        int          nbytes;
        if (dec_phase != PH_HALT) begin
            if (c == CH_NUL) begin
                dec_phase = PH_HALT;
            end else if (c == CH_DASH) begin
                dash_cnt = dash_cnt + 3'd1;
                if (dash_cnt >= RUN_LEN) begin
                    dash_cnt = '0;
                    case (dec_phase)
                        PH_SEEK: dec_phase = PH_OPEN;
                        PH_OPEN: begin
                            clear_group_state();
                            dec_phase = PH_BODY;
                        end
                        PH_BODY: begin
                            if (grp_fill != 0) body_bad = 1'b1;
                            dec_phase = PH_CLOSE;
                        end
                        PH_CLOSE: begin
                            if (body_bad) begin
                                step_out.push_back('{KIND_ERR, 8'h00, 1'b0});
                                dec_phase = PH_HALT;
                            end else begin
                                step_out.push_back('{KIND_END, 8'h00, 1'b0});
                                dec_phase = PH_SEEK;
                            end
                            clear_group_state();
                        end
                        default: ;
                    endcase
                end
            end else begin
                if (dec_phase == PH_BODY) begin
                    if (dash_cnt != 0) body_bad = 1'b1;
                    if (c != CH_CR && c != CH_LF && c != CH_TAB && c != CH_SPACE
                        && !body_bad) begin
                        take = 1'b0;
                        v = '0;
                        if (c == CH_PAD) begin
                            if (grp_fill < 2) begin
                                body_bad = 1'b1;
                            end else begin
                                pad_cnt = pad_cnt + 2'd1;
                                take = 1'b1;
                            end
                        end else begin
                            sv = b64_value(c);
                            if (sv[6] || pad_cnt != 0) begin
                                body_bad = 1'b1;
                            end else begin
                                v = sv[5:0];
                                take = 1'b1;
                            end
                        end
                        if (take) begin
                            if (grp_fill < 3) begin
                                grp_bits = {grp_bits[11:0], v};
                                grp_fill = grp_fill + 2'd1;
                            end else begin
                                word = {grp_bits, v};
                                nbytes = 3 - ((pad_cnt > 2) ? 2 : pad_cnt);
                                for (int i = 0; i < nbytes; i++) begin
                                    step_out.push_back('{KIND_DATA, word[23 - 8*i -: 8], 1'b0});
                                end
                                grp_fill = '0;
                                grp_bits = '0;
                            end
                        end
                    end
                end
                dash_cnt = '0;
            end
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) decoded_q.push_back(step_out[i]);
        if (fe) reset_model();
    endfunction

    // ---------------- stimulus ----------------

    task automatic push_char(input logic [7:0] c, input logic fe);
        text_q.push_back('{c, fe});
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 3))
            0: return CH_CR;
            1: return CH_LF;
            2: return CH_TAB;
            default: return CH_SPACE;
        endcase
    endfunction

    task automatic put_in_body(input logic [7:0] c);
        int pos;
        pos = $urandom_range(0, cert_body.size());
        if (pos >= cert_body.size()) cert_body.push_back(c);
        else cert_body.insert(pos, c);
    endtask

    task automatic push_label();
        int k;
        k = $urandom_range(0, 8);
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 9) == 0) push_char(CH_SPACE, 1'b0);
            else push_char(8'("A" + $urandom_range(0, 25)), 1'b0);
        end
    endtask

    task automatic add_noise();
        int k;
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) push_char(8'($urandom_range(1, 255)), 1'b0);
        if ($urandom_range(0, 3) == 0) begin
            push_char(CH_NUL, 1'b1);
            k++;
        end
        noise_items += k;
    endtask

    task automatic add_cert(input t_fault flt);
        int          n;
        int          k;
        logic [23:0] w;
        logic [7:0]  c;
        logic [6:0]  sv;
        logic        fe;
        cert_body.delete();
        push_text("-----");
        push_label();
        push_text("-----");
        if ($urandom_range(0, 1)) push_char(CH_LF, 1'b0);

        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 48) : $urandom_range(0, 9);
        for (int i = 0; i < n; i += 3) begin
            w = 24'($urandom);
            cert_body.push_back(b64_symbol(w[23:18]));
            cert_body.push_back(b64_symbol(w[17:12]));
            if (n - i == 1) begin
                cert_body.push_back(CH_PAD);
                cert_body.push_back(CH_PAD);
            end else if (n - i == 2) begin
                cert_body.push_back(b64_symbol(w[11:6]));
                cert_body.push_back(CH_PAD);
            end else begin
                cert_body.push_back(b64_symbol(w[11:6]));
                cert_body.push_back(b64_symbol(w[5:0]));
            end
        end

        case (flt)
            FLT_BADCHAR: begin
                do begin
                    c = 8'($urandom_range(1, 255));
                    sv = b64_value(c);
                end while (!sv[6] || c == CH_DASH || c == CH_PAD || c == CH_CR
                           || c == CH_LF || c == CH_TAB || c == CH_SPACE);
                put_in_body(c);
            end
            FLT_STRAY_DASH: begin
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++) put_in_body(CH_DASH);
            end
            FLT_PARTIAL: begin
                if (cert_body.size() >= 4) begin
                    k = $urandom_range(1, 3);
                    for (int i = 0; i < k; i++) void'(cert_body.pop_back());
                end else begin
                    k = $urandom_range(1, 3);
                    for (int i = 0; i < k; i++) cert_body.push_back(b64_symbol(6'($urandom)));
                end
            end
            FLT_PAD_EARLY: put_in_body(CH_PAD);
            FLT_AFTER_PAD: begin
                cert_body.push_back("Q");
                cert_body.push_back("Q");
                cert_body.push_back(CH_PAD);
                if ($urandom_range(0, 1)) cert_body.push_back(CH_PAD);
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++) cert_body.push_back(b64_symbol(6'($urandom)));
            end
            FLT_ZERO: put_in_body(CH_NUL);
            default: ;
        endcase

        k = (flt == FLT_TRUNCATE) ? $urandom_range(0, cert_body.size()) : cert_body.size();
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 5) == 0) push_char(pick_space(), 1'b0);
            push_char(cert_body[i], 1'b0);
        end
        if (flt == FLT_TRUNCATE) begin
            push_char(CH_LF, 1'b1);
        end else begin
            if ($urandom_range(0, 1)) push_char(CH_LF, 1'b0);
            push_text("-----");
            push_label();
            // an extra dash now and then runs past the closing marker
            if ($urandom_range(0, 5) == 0) push_text("------");
            else push_text("-----");
            if (flt == FLT_NONE) fe = ($urandom_range(0, 7) == 0);
            else fe = ($urandom_range(0, 7) != 0);
            push_char(CH_LF, fe);
        end
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            text_if.valid    <= 1'b0;
            text_if.in_byte  <= 8'h00;
            text_if.file_end <= 1'b0;
            send_gap = 0;
        end else begin
            if (text_if.valid && text_if.ready) begin
                decode_step(text_if.in_byte, text_if.file_end);
            end
            if (text_if.ready || !text_if.valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                    text_if.valid <= 1'b0;
                end else if (text_q.size() > 0) begin
                    sent_item = text_q.pop_front();
                    text_if.valid    <= 1'b1;
                    text_if.in_byte  <= sent_item.ch;
                    text_if.file_end <= sent_item.fe;
                    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 3);
                end else begin
                    text_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dec_if.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (dec_if.valid && dec_if.ready) begin
                if (decoded_q.size() == 0) begin
                    flag_mismatch($sformatf("result with nothing pending: kind %0d byte %02h",
                                            dec_if.kind, dec_if.data_byte));
                end else begin
                    want = decoded_q.pop_front();
                    if (dec_if.kind !== want.kind)
                        flag_mismatch($sformatf("kind %0d, predicted %0d",
                                                dec_if.kind, want.kind));
                    if (dec_if.data_byte !== want.data_byte)
                        flag_mismatch($sformatf("data_byte %02h, predicted %02h",
                                                dec_if.data_byte, want.data_byte));
                    if (dec_if.last !== want.last)
                        flag_mismatch($sformatf("last %0b, predicted %0b",
                                                dec_if.last, want.last));
                end
                if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 3);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                dec_if.ready <= 1'b0;
            end else begin
                dec_if.ready <= 1'b1;
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        int r;
        i_rst_n          = 1'b0;
        text_if.valid    = 1'b0;
        text_if.in_byte  = 8'h00;
        text_if.file_end = 1'b0;
        dec_if.ready     = 1'b0;
        noise_items = 0;
        fail_count  = 0;
        send_burst  = 1'b0;
        recv_burst  = 1'b0;
        reset_model();

        // byte extremes outside a certificate, a bare certificate, a zero with file end
        push_char(8'hFF, 1'b0);
        push_char(8'h7F, 1'b0);
        push_text("----------+/Az");
        push_text("----------");
        push_char(CH_NUL, 1'b1);

        while (text_q.size() - noise_items < TEXT_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 12) add_noise();
            else if (r < 60) add_cert(FLT_NONE);
            else add_cert(t_fault'($urandom_range(FLT_BADCHAR, FLT_TRUNCATE)));
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_q.size() != 0 || text_if.valid) @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
